FILE: hdl/lzw_variable_width_decoder_core_defines.svh
// Assertion macros shared by the LZW decoder RTL.
// Both expect clk and arst_n in the scope of use.
`ifndef LZW_VARIABLE_WIDTH_DECODER_CORE_DEFINES_SVH
`define LZW_VARIABLE_WIDTH_DECODER_CORE_DEFINES_SVH

// same-cycle implication
`define LZWVD_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define LZWVD_ASSERT_NXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/lzwvd_pkg.sv
`timescale 1ns / 1ps

package lzwvd_pkg;

	localparam int STACK_DEPTH = 4096;
	localparam int STACK_AW    = 12;

	localparam logic [11:0] CLEAR_CODE       = 12'd256;
	localparam logic [11:0] FIRST_TABLE_CODE = 12'd256;
	localparam logic [12:0] FIRST_FREE       = 13'd257;
	localparam logic [12:0] CLEAR_FREE       = 13'd256;
	localparam logic [12:0] WALK_LIMIT       = 13'd4095;
	localparam logic [3:0]  MIN_WIDTH        = 4'd9;
	localparam logic [3:0]  MAX_WIDTH        = 4'd12;

	localparam logic OP_PUSH  = 1'b0;
	localparam logic OP_DRAIN = 1'b1;

	// controller -> datapath
	typedef struct packed {
		logic item_start;
		logic begin_byte;
		logic drop_byte;
		logic byte_end;
		logic bit_step;
		logic dec_start;
		logic walk_zero;
		logic walk_data;
		logic dec_finish;
		logic dec_after;
		logic tail_begin;
		logic tail_end;
		logic pop;
		logic res_wr;
		logic out_next;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic refused;
		logic drain;
		logic ended;
		logic drop_nz;
		logic code_done;
		logic bit_last;
		logic dec_short;
		logic walk_more;
		logic walk_in_table;
		logic clear_hit;
		logic res_full;
		logic stack_nz;
		logic tail;
		logic out_last;
	} stat_t;

endpackage

FILE: hdl/lzwvd_in_if.sv
`timescale 1ns / 1ps

interface lzwvd_in_if;
	logic       valid;
	logic       ready;
	logic       operation;
	logic [7:0] in_byte;
	logic       stream_end;

	modport source (output valid, operation, in_byte, stream_end, input ready);
	modport sink (input valid, operation, in_byte, stream_end, output ready);
endinterface

FILE: hdl/lzwvd_out_if.sv
`timescale 1ns / 1ps

interface lzwvd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       byte_valid;
	logic       run_last;
	logic       input_accepted;
	logic       output_pending;
	logic       finished;

	modport source (output valid, out_byte, byte_valid, run_last, input_accepted,
		output_pending, finished, input ready);
	modport sink (input valid, out_byte, byte_valid, run_last, input_accepted,
		output_pending, finished, output ready);
endinterface

FILE: hdl/lzwvd_dp.sv
`timescale 1ns / 1ps

module lzwvd_dp #(
	parameter int TABLE_ENTRIES    = 4096,
	parameter int RESULTS_PER_ITEM = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  lzwvd_pkg::cmd_t  cmd,
	output lzwvd_pkg::stat_t st,
	input  logic             in_op,
	input  logic [7:0]       in_data,
	input  logic             in_end,
	output logic [7:0]       out_byte,
	output logic             byte_valid,
	output logic             run_last,
	output logic             input_accepted,
	output logic             output_pending,
	output logic             finished
);

	localparam int AW = $clog2(TABLE_ENTRIES);
	localparam int NW = $clog2(RESULTS_PER_ITEM + 1);
	localparam int RW = (RESULTS_PER_ITEM > 1) ? $clog2(RESULTS_PER_ITEM) : 1;
	localparam logic [12:0]   TE_LIM = 13'(TABLE_ENTRIES);
	localparam logic [NW-1:0] N_MAX  = NW'(RESULTS_PER_ITEM);

	// memories
	logic [11:0] prefix_mem [TABLE_ENTRIES];
	logic [7:0]  append_mem [TABLE_ENTRIES];
	logic [7:0]  stack_mem  [lzwvd_pkg::STACK_DEPTH];
	logic [7:0]  res_mem    [RESULTS_PER_ITEM];
	logic [11:0] pre_rd_q;
	logic [7:0]  app_rd_q, stk_rd_q, res_rd_q;

	// item
	logic       op_q, end_q, acc_q;
	logic [7:0] byte_q;
	logic [2:0] bit_q;
	// bit gathering
	logic [11:0] gather_q;
	logic [3:0]  gathered_q;
	// decoder state
	logic [3:0]  width_q;
	logic [12:0] nf_q;
	logic [11:0] prev_q, cur_q, code_q;
	logic [7:0]  lfb_q;
	logic [6:0]  big_q;
	logic [3:0]  drop_q, drops_after_q, skip_q;
	logic        first_q, ended_q, tail_q, clear_q;
	logic [12:0] fill_q;
	// result buffer
	logic [NW-1:0] n_q;
	logic [RW-1:0] k_q;

	logic        push_en;
	logic [7:0]  push_val;
	logic [11:0] gath_nx;
	logic [6:0]  grp, bn_sum, bn;
	logic [6:0]  skip_span;
	logic [12:0] nf_inc;
	logic        tbl_we;

	assign gath_nx   = gather_q | ({11'd0, byte_q[bit_q]} << gathered_q);
	assign grp       = {width_q, 3'd0};
	assign bn_sum    = big_q + {3'd0, width_q};
	assign bn        = (bn_sum >= grp) ? bn_sum - grp : bn_sum;
	assign skip_span = grp - bn;
	assign nf_inc    = nf_q + 13'd1;
	assign tbl_we    = cmd.dec_finish && (nf_q < TE_LIM);

	always_comb begin
		push_en  = 1'b0;
		push_val = 8'd0;
		priority if (cmd.dec_start && !first_q) begin
			push_en  = 1'b1;
			push_val = cur_q[7:0];
		end else if (cmd.dec_start && cur_q != lzwvd_pkg::CLEAR_CODE
				&& {1'b0, cur_q} >= nf_q) begin
			push_en  = 1'b1;
			push_val = lfb_q;
		end else if (cmd.walk_zero) begin
			push_en  = 1'b1;
		end else if (cmd.walk_data) begin
			push_en  = 1'b1;
			push_val = app_rd_q;
		end else if (cmd.dec_finish) begin
			push_en  = 1'b1;
			push_val = code_q[7:0];
		end else begin
			push_en  = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tbl_we) begin
			prefix_mem[nf_q[AW-1:0]] <= prev_q;
			append_mem[nf_q[AW-1:0]] <= code_q[7:0];
		end
		pre_rd_q <= prefix_mem[code_q[AW-1:0]];
		app_rd_q <= append_mem[code_q[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (push_en && !fill_q[12])
			stack_mem[fill_q[11:0]] <= push_val;
		stk_rd_q <= stack_mem[fill_q[11:0] - 12'd1];
	end

	always_ff @(posedge clk) begin
		if (cmd.res_wr)
			res_mem[n_q[RW-1:0]] <= stk_rd_q;
		res_rd_q <= res_mem[k_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q          <= lzwvd_pkg::OP_PUSH;
			end_q         <= 1'b0;
			acc_q         <= 1'b1;
			byte_q        <= 8'd0;
			bit_q         <= 3'd0;
			gather_q      <= 12'd0;
			gathered_q    <= 4'd0;
			width_q       <= lzwvd_pkg::MIN_WIDTH;
			nf_q          <= lzwvd_pkg::FIRST_FREE;
			prev_q        <= 12'd0;
			cur_q         <= 12'd0;
			code_q        <= 12'd0;
			lfb_q         <= 8'd0;
			big_q         <= 7'd0;
			drop_q        <= 4'd0;
			drops_after_q <= 4'd0;
			skip_q        <= 4'd0;
			first_q       <= 1'b0;
			ended_q       <= 1'b0;
			tail_q        <= 1'b0;
			clear_q       <= 1'b0;
			fill_q        <= 13'd0;
			n_q           <= '0;
			k_q           <= '0;
		end else begin
			if (cmd.item_start) begin
				op_q   <= in_op;
				byte_q <= in_data;
				end_q  <= in_end;
				acc_q  <= !(in_op == lzwvd_pkg::OP_PUSH && (fill_q != 13'd0 || tail_q));
				n_q    <= '0;
				k_q    <= '0;
			end
			if (cmd.drop_byte)
				drop_q <= drop_q - 4'd1;
			if (cmd.begin_byte) begin
				drop_q        <= drops_after_q;
				drops_after_q <= 4'd0;
				bit_q         <= 3'd0;
			end
			if (cmd.byte_end && end_q) begin
				if (gathered_q != 4'd0)
					tail_q <= 1'b1;
				else
					ended_q <= 1'b1;
			end
			if (cmd.bit_step) begin
				if (st.code_done) begin
					cur_q      <= gath_nx;
					gather_q   <= 12'd0;
					gathered_q <= 4'd0;
				end else begin
					gather_q   <= gath_nx;
					gathered_q <= gathered_q + 4'd1;
					if (!st.bit_last)
						bit_q <= bit_q + 3'd1;
				end
			end
			if (cmd.dec_start) begin
				clear_q <= 1'b0;
				if (!first_q) begin
					first_q <= 1'b1;
					prev_q  <= cur_q;
					lfb_q   <= cur_q[7:0];
				end else if (cur_q == lzwvd_pkg::CLEAR_CODE) begin
					clear_q <= 1'b1;
					skip_q  <= (bn != 7'd0) ? skip_span[6:3] : 4'd0;
					width_q <= lzwvd_pkg::MIN_WIDTH;
					nf_q    <= lzwvd_pkg::CLEAR_FREE;
					big_q   <= 7'd0;
				end else begin
					big_q  <= bn;
					// code not yet in table: restart from the previous code
					code_q <= ({1'b0, cur_q} >= nf_q) ? prev_q : cur_q;
				end
			end
			if (cmd.walk_zero)
				code_q <= 12'd0;
			if (cmd.walk_data)
				code_q <= pre_rd_q;
			if (cmd.dec_finish) begin
				lfb_q  <= code_q[7:0];
				prev_q <= cur_q;
				if (tbl_we) begin
					nf_q <= nf_inc;
					if (nf_inc >= (13'd1 << width_q) && width_q < lzwvd_pkg::MAX_WIDTH) begin
						width_q <= width_q + 4'd1;
						big_q   <= 7'd0;
					end
				end
			end
			if (cmd.dec_after) begin
				if (clear_q) begin
					drops_after_q <= skip_q;
					if (!st.bit_last)
						drop_q <= drop_q + 4'd1;
				end else if (!st.bit_last) begin
					bit_q <= bit_q + 3'd1;
				end
			end
			if (cmd.tail_begin) begin
				tail_q <= 1'b0;
				cur_q  <= gather_q;
			end
			if (cmd.tail_end) begin
				gather_q   <= 12'd0;
				gathered_q <= 4'd0;
				ended_q    <= 1'b1;
			end
			if (cmd.pop)
				fill_q <= fill_q - 13'd1;
			else if (push_en && !fill_q[12])
				fill_q <= fill_q + 13'd1;
			if (cmd.res_wr)
				n_q <= n_q + NW'(1);
			if (cmd.out_next)
				k_q <= k_q + RW'(1);
		end
	end

	always_comb begin
		st.refused       = !acc_q;
		st.drain         = (op_q == lzwvd_pkg::OP_DRAIN);
		st.ended         = ended_q;
		st.drop_nz       = (drop_q != 4'd0);
		st.code_done     = ((gathered_q + 4'd1) >= width_q);
		st.bit_last      = (bit_q == 3'd7);
		st.dec_short     = !first_q || (cur_q == lzwvd_pkg::CLEAR_CODE);
		st.walk_more     = (code_q >= lzwvd_pkg::FIRST_TABLE_CODE)
			&& (fill_q < lzwvd_pkg::WALK_LIMIT);
		st.walk_in_table = ({1'b0, code_q} < TE_LIM);
		st.clear_hit     = clear_q;
		st.res_full      = (n_q == N_MAX);
		st.stack_nz      = (fill_q != 13'd0);
		st.tail          = tail_q;
		st.out_last      = (n_q == '0) || ((NW'(k_q) + NW'(1)) == n_q);
	end

	assign out_byte       = (n_q == '0) ? 8'd0 : res_rd_q;
	assign byte_valid     = (n_q != '0);
	assign run_last       = st.out_last;
	assign input_accepted = acc_q;
	assign output_pending = (fill_q != 13'd0) || tail_q;
	assign finished       = ended_q;

endmodule

FILE: hdl/lzwvd_ctrl.sv
`timescale 1ns / 1ps

module lzwvd_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  lzwvd_pkg::stat_t st,
	output lzwvd_pkg::cmd_t  cmd
);

	typedef enum logic [12:0] {
		S_IDLE       = 13'b0000000000001,
		S_DISPATCH   = 13'b0000000000010,
		S_BIT        = 13'b0000000000100,
		S_DEC_START  = 13'b0000000001000,
		S_WALK       = 13'b0000000010000,
		S_WALK_DATA  = 13'b0000000100000,
		S_DEC_FINISH = 13'b0000001000000,
		S_DEC_DONE   = 13'b0000010000000,
		S_BYTE_END   = 13'b0000100000000,
		S_EMIT       = 13'b0001000000000,
		S_POP_WR     = 13'b0010000000000,
		S_OUT_RD     = 13'b0100000000000,
		S_OUT_SEND   = 13'b1000000000000
	} state_t;

	state_t state_q, state_d;
	logic   tail_ctx_q, tail_ctx_d;

	always_comb begin
		state_d    = state_q;
		tail_ctx_d = tail_ctx_q;
		cmd        = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.item_start = 1'b1;
					state_d        = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				priority if (st.refused) begin
					state_d = S_OUT_RD;
				end else if (st.drain || st.ended) begin
					state_d = S_EMIT;
				end else if (st.drop_nz) begin
					cmd.drop_byte = 1'b1;
					cmd.byte_end  = 1'b1;
					state_d       = S_EMIT;
				end else begin
					cmd.begin_byte = 1'b1;
					state_d        = S_BIT;
				end
			end
			S_BIT: begin
				cmd.bit_step = 1'b1;
				if (st.code_done) begin
					tail_ctx_d = 1'b0;
					state_d    = S_DEC_START;
				end else if (st.bit_last) begin
					state_d = S_BYTE_END;
				end
			end
			S_DEC_START: begin
				cmd.dec_start = 1'b1;
				state_d       = st.dec_short ? S_DEC_DONE : S_WALK;
			end
			S_WALK: begin
				if (st.walk_more) begin
					if (st.walk_in_table)
						state_d = S_WALK_DATA;
					else
						cmd.walk_zero = 1'b1;
				end else begin
					state_d = S_DEC_FINISH;
				end
			end
			S_WALK_DATA: begin
				cmd.walk_data = 1'b1;
				state_d       = S_WALK;
			end
			S_DEC_FINISH: begin
				cmd.dec_finish = 1'b1;
				state_d        = S_DEC_DONE;
			end
			S_DEC_DONE: begin
				if (tail_ctx_q) begin
					cmd.tail_end = 1'b1;
					state_d      = S_EMIT;
				end else begin
					cmd.dec_after = 1'b1;
					state_d       = (st.clear_hit || st.bit_last) ? S_BYTE_END : S_BIT;
				end
			end
			S_BYTE_END: begin
				cmd.byte_end = 1'b1;
				state_d      = S_EMIT;
			end
			S_EMIT: begin
				priority if (!st.res_full && st.stack_nz) begin
					cmd.pop = 1'b1;
					state_d = S_POP_WR;
				end else if (!st.res_full && st.tail) begin
					cmd.tail_begin = 1'b1;
					tail_ctx_d     = 1'b1;
					state_d        = S_DEC_START;
				end else begin
					state_d = S_OUT_RD;
				end
			end
			S_POP_WR: begin
				cmd.res_wr = 1'b1;
				state_d    = S_EMIT;
			end
			S_OUT_RD: state_d = S_OUT_SEND;
			S_OUT_SEND: begin
				if (out_ready) begin
					if (st.out_last) begin
						state_d = S_IDLE;
					end else begin
						cmd.out_next = 1'b1;
						state_d      = S_OUT_RD;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			tail_ctx_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			tail_ctx_q <= tail_ctx_d;
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT_SEND);

endmodule

FILE: hdl/lzw_variable_width_decoder_core.sv
// Order: a push offers its first word only after its codes are decoded, their table links
//   walked and their bytes collected into the result buffer.
// Throughput: one item at a time, with no new item taken before the last word of the previous
//   one; each word is collected (pop, then write) and presented (read, then send).
// Reset: arst_n clears all control state at once; table, stack and result memories
//   hold no reset and are only read where written.
`timescale 1ns / 1ps

`include "lzw_variable_width_decoder_core_defines.svh"

module lzw_variable_width_decoder_core #(
	parameter int TABLE_ENTRIES    = 4096,
	parameter int RESULTS_PER_ITEM = 64
) (
	input logic           clk,
	input logic           arst_n,
	lzwvd_in_if.sink      din,
	lzwvd_out_if.source   dout
);

	// Controller sequences bit gathering, chain walk and output collection;
	// datapath holds the code state, the prefix/append table, the reverse
	// stack and a result buffer that is filled before the first word leaves,
	// so every word of an item carries the status left after the item.
	lzwvd_pkg::cmd_t  cmd;
	lzwvd_pkg::stat_t st;

	lzwvd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (din.valid),
		.in_ready  (din.ready),
		.out_valid (dout.valid),
		.out_ready (dout.ready),
		.st        (st),
		.cmd       (cmd)
	);

	lzwvd_dp #(
		.TABLE_ENTRIES    (TABLE_ENTRIES),
		.RESULTS_PER_ITEM (RESULTS_PER_ITEM)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.st             (st),
		.in_op          (din.operation),
		.in_data        (din.in_byte),
		.in_end         (din.stream_end),
		.out_byte       (dout.out_byte),
		.byte_valid     (dout.byte_valid),
		.run_last       (dout.run_last),
		.input_accepted (dout.input_accepted),
		.output_pending (dout.output_pending),
		.finished       (dout.finished)
	);

	// output side and input side never active together
	`LZWVD_ASSERT_IMP(a_out_excl_in, dout.valid, !din.ready, "word offered while taking input")
	// a taken item keeps the block busy in the following cycle
	`LZWVD_ASSERT_NXT(a_busy_after_take, din.valid && din.ready, !din.ready, "ready after take")
	// the last word of an item returns the block to idle
	`LZWVD_ASSERT_NXT(a_idle_after_last, dout.valid && dout.ready && dout.run_last, din.ready,
		"not idle after last word")
	// a refused push answers with exactly one empty status word
	`LZWVD_ASSERT_IMP(a_refuse_single, dout.valid && !dout.input_accepted,
		dout.run_last && !dout.byte_valid && dout.output_pending, "bad refusal word")

endmodule
